FILE: hdl/wals_pkg.sv
// ----------------------------------------------------------------------------
// wals_pkg
// Shared types and constants for the wrapped angle limit and speed block.
// ----------------------------------------------------------------------------
package wals_pkg;

	localparam int AXIS_COUNT = 2;

	localparam logic [15:0] TURN_UNITS = 16'd36000;
	localparam int          HALF_TURN  = 18000;
	localparam logic [7:0]  SPEED_MIN  = 8'd1;
	localparam logic [7:0]  SPEED_MAX  = 8'd150;
	localparam logic [15:0] FULL_ERR   = 16'd6000;

	localparam logic [15:0] AXIS0_LOW_RESET  = 16'd34500;
	localparam logic [15:0] AXIS0_HIGH_RESET = 16'd1500;
	localparam logic [15:0] AXIS1_LOW_RESET  = 16'd27000;
	localparam logic [15:0] AXIS1_HIGH_RESET = 16'd9000;

	// Division by FULL_ERR is done as a shift by 4 followed by a multiply with
	// the rounded-up reciprocal of 375, exact for all quotients in range.
	localparam int          DIV_PRE_SHIFT = 4;
	localparam logic [15:0] RECIP_375     = 16'd44740;
	localparam int          RECIP_SHIFT   = 24;

	typedef enum logic [1:0] {
		REG_AXIS0_LOW,
		REG_AXIS0_HIGH,
		REG_AXIS1_LOW,
		REG_AXIS1_HIGH
	} reg_index_t;

	typedef struct packed {
		logic        axis;
		logic [15:0] lim;
		logic [31:0] enc_scaled;
	} front_t;

	typedef struct packed {
		logic        dir;
		logic        sat;
		logic [12:0] err;
		logic [15:0] lim;
	} error_t;

	typedef struct packed {
		logic [7:0]  speed;
		logic        dir;
		logic [15:0] lim;
	} result_t;

endpackage

FILE: hdl/wals_front.sv
// ----------------------------------------------------------------------------
// wals_front
// Input register, limit registers, target wrap and arc clamp, encoder scaling.
// ----------------------------------------------------------------------------
module wals_front import wals_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        axis_select,
	input  logic [15:0] target_position,
	input  logic [15:0] encoder_reading,
	output logic        out_valid,
	input  logic        out_ready,
	output front_t      out_data
);

	logic        valid_s1;
	logic        axis_s1;
	logic [15:0] tgt_s1;
	logic [15:0] enc_s1;
	logic        valid_s2;
	front_t      data_s2;
	logic [15:0] low_q  [AXIS_COUNT];
	logic [15:0] high_q [AXIS_COUNT];

	logic        ready_s1;
	logic        ready_s2;
	logic [15:0] tgt_wrap;
	logic [15:0] lo;
	logic [15:0] hi;
	logic [15:0] lim;
	front_t      next_s2;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q[0]  <= AXIS0_LOW_RESET;
			high_q[0] <= AXIS0_HIGH_RESET;
			low_q[1]  <= AXIS1_LOW_RESET;
			high_q[1] <= AXIS1_HIGH_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_AXIS0_LOW:  low_q[0]  <= cfg_data;
				REG_AXIS0_HIGH: high_q[0] <= cfg_data;
				REG_AXIS1_LOW:  low_q[1]  <= cfg_data;
				REG_AXIS1_HIGH: high_q[1] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			axis_s1 <= axis_select;
			tgt_s1  <= target_position;
			enc_s1  <= encoder_reading;
		end
		if (valid_s1 && ready_s2) begin
			data_s2 <= next_s2;
		end
	end

	always_comb begin
		tgt_wrap = (tgt_s1 >= TURN_UNITS) ? tgt_s1 - TURN_UNITS : tgt_s1;
		lo = low_q[axis_s1];
		hi = high_q[axis_s1];
		if (tgt_wrap >= lo || tgt_wrap <= hi) begin
			lim = tgt_wrap;
		end else if ((tgt_wrap - hi) <= (lo - tgt_wrap)) begin
			lim = hi;
		end else begin
			lim = lo;
		end
		next_s2.axis       = axis_s1;
		next_s2.lim        = lim;
		next_s2.enc_scaled = 32'(enc_s1) * 32'(TURN_UNITS) + 32'd32768;
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

FILE: hdl/wals_error.sv
// ----------------------------------------------------------------------------
// wals_error
// Wrapped error, per-axis turn direction and error magnitude.
// ----------------------------------------------------------------------------
module wals_error import wals_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  front_t in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output error_t out_data
);

	localparam logic signed [17:0] HalfPos = 18'(HALF_TURN);
	localparam logic signed [17:0] HalfNeg = -HalfPos;
	localparam logic signed [17:0] TurnS   = 18'(TURN_UNITS);

	logic   valid_s3;
	error_t data_s3;
	logic   last_dir_q [AXIS_COUNT];

	logic               ready_s3;
	logic [15:0]        cur;
	logic signed [17:0] diff;
	logic signed [17:0] wrapped;
	logic signed [17:0] mag;
	logic [14:0]        err;
	logic               dir_new;
	error_t             next_s3;

	assign ready_s3 = !valid_s3 || out_ready;
	assign in_ready = ready_s3;

	always_comb begin
		cur  = in_data.enc_scaled[31:16];
		diff = $signed({2'b00, in_data.lim}) - $signed({2'b00, cur});
		if (diff > HalfPos) begin
			wrapped = diff - TurnS;
		end else if (diff < HalfNeg) begin
			wrapped = diff + TurnS;
		end else begin
			wrapped = diff;
		end
		mag = (wrapped < 0) ? -wrapped : wrapped;
		err = mag[14:0];
		if (wrapped > 0) begin
			dir_new = 1'b0;
		end else if (wrapped < 0) begin
			dir_new = 1'b1;
		end else begin
			dir_new = last_dir_q[in_data.axis];
		end
		next_s3.dir = dir_new;
		next_s3.sat = (err >= 15'(FULL_ERR));
		next_s3.err = err[12:0];
		next_s3.lim = in_data.lim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			for (int i = 0; i < AXIS_COUNT; i++) begin
				last_dir_q[i] <= 1'b0;
			end
		end else begin
			if (ready_s3) begin
				valid_s3 <= in_valid;
			end
			if (in_valid && ready_s3) begin
				last_dir_q[in_data.axis] <= dir_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s3) begin
			data_s3 <= next_s3;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

FILE: hdl/wals_speed.sv
// ----------------------------------------------------------------------------
// wals_speed
// Speed ceiling from the error magnitude, and the result register.
// ----------------------------------------------------------------------------
module wals_speed import wals_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  error_t  in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	localparam logic [19:0] Slope = 20'(SPEED_MAX - SPEED_MIN);

	logic        valid_s4;
	logic [19:0] prod_s4;
	logic        dir_s4;
	logic        sat_s4;
	logic [15:0] lim_s4;
	logic        valid_s5;
	result_t     data_s5;

	logic        ready_s4;
	logic        ready_s5;
	logic [15:0] scaled;
	logic [31:0] quot_full;
	logic [7:0]  quot;
	result_t     next_s5;

	assign ready_s5 = !valid_s5 || out_ready;
	assign ready_s4 = !valid_s4 || ready_s5;
	assign in_ready = ready_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready_s4) begin
				valid_s4 <= in_valid;
			end
			if (ready_s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s4) begin
			prod_s4 <= 20'(in_data.err) * Slope;
			dir_s4  <= in_data.dir;
			sat_s4  <= in_data.sat;
			lim_s4  <= in_data.lim;
		end
		if (valid_s4 && ready_s5) begin
			data_s5 <= next_s5;
		end
	end

	always_comb begin
		scaled        = prod_s4[DIV_PRE_SHIFT +: 16];
		quot_full     = 32'(scaled) * 32'(RECIP_375);
		quot          = quot_full[RECIP_SHIFT +: 8];
		next_s5.speed = sat_s4 ? SPEED_MAX : quot + SPEED_MIN;
		next_s5.dir   = dir_s4;
		next_s5.lim   = lim_s4;
	end

	assign out_valid = valid_s5;
	assign out_data  = data_s5;

endmodule

FILE: hdl/wrapped_angle_limit_and_speed.sv
// ----------------------------------------------------------------------------
// wrapped_angle_limit_and_speed
// Head axis position command: target wrap, arc clamp, direction and speed.
// ----------------------------------------------------------------------------
// The block takes one command word per clock cycle while the pipeline has
// room, and returns one result word for each, in order, five register stages
// after it is taken: input register, clamp and encoder scaling, wrapped error
// and direction, speed product, and the result register. Each stage holds its
// word on its own, so words keep entering while a finished result waits, until
// all stages are full. Write the limit registers through the configuration
// port only while no command is in flight; the block does not enforce this.
module wrapped_angle_limit_and_speed import wals_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // target_position, encoder_reading
	input  logic        s_tuser,  // axis_select
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // limited_target, turn_direction, speed_cap, zeros
);

	logic    front_valid;
	logic    front_ready;
	front_t  front_data;
	logic    err_valid;
	logic    err_ready;
	error_t  err_data;
	result_t result;

	wals_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.axis_select     (s_tuser),
		.target_position (s_tdata[15:0]),
		.encoder_reading (s_tdata[31:16]),
		.out_valid       (front_valid),
		.out_ready       (front_ready),
		.out_data        (front_data)
	);

	wals_error u_error (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_data   (front_data),
		.out_valid (err_valid),
		.out_ready (err_ready),
		.out_data  (err_data)
	);

	wals_speed u_speed (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (err_valid),
		.in_ready  (err_ready),
		.in_data   (err_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (result)
	);

	assign m_tdata = {7'd0, result.speed, result.dir, result.lim};

endmodule
